>>> src/csb_pkg.sv
// shared constants, codes and types for the coverage span blender
// no dependencies; used by csb_blend and coverage_span_blend_rgb565_core
package csb_pkg;

   // frame store geometry
   localparam int FB_WIDTH   = 320;
   localparam int FB_HEIGHT  = 240;
   localparam int STORE_SIZE = FB_WIDTH * FB_HEIGHT;
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   // row base is an 8-bit row times a 9-bit stride
   localparam int BASE_W = 17;
   localparam int SUM_W  = (ADDR_W + 1 > BASE_W + 1) ? ADDR_W + 1 : BASE_W + 1;

   localparam logic [7:0] FULL_COVER = 8'hFF;

   // operation codes
   localparam logic [1:0] OP_BLEND = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FILL_COLOUR   = 2'd0;
   localparam logic [1:0] CSR_ACTIVE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_ROW_STRIDE    = 2'd3;

   // store write request from the blend pipeline
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       data;
   } blend_wr_type;

endpackage

>>> src/csb_blend.sv
// two-stage rgb565 coverage blend pipeline feeding the frame store write port
// depends on csb_pkg
module csb_blend (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [csb_pkg::ADDR_W-1:0] in_addr,
   input  logic [15:0]                in_pixel,
   input  logic [23:0]                colour,
   input  logic [7:0]                 alpha,
   output csb_pkg::blend_wr_type      wr_out,
   output logic                       busy
);

   logic                       a_valid_ff;
   logic [csb_pkg::ADDR_W-1:0] a_addr_ff;
   logic [15:0]                a_sum_r_ff, a_sum_g_ff, a_sum_b_ff;
   logic [15:0]                a_sum_r_in, a_sum_g_in, a_sum_b_in;
   csb_pkg::blend_wr_type      wr_ff, wr_in;
   logic [7:0]                 inv_alpha;
   logic [7:0]                 pix_r, pix_g, pix_b;
   logic [7:0]                 q_r, q_g, q_b;
   logic [15:0]                solid;

   // exact floor(s/255) for s below 65280
   function automatic logic [7:0] div255(input logic [15:0] s);
      logic [16:0] t;
      t = {1'b0, s} + 17'd1 + {9'd0, s[15:8]};
      return t[15:8];
   endfunction

   // unpack without bit replication
   assign pix_r     = {in_pixel[15:11], 3'b000};
   assign pix_g     = {in_pixel[10:5], 2'b00};
   assign pix_b     = {in_pixel[4:0], 3'b000};
   assign inv_alpha = csb_pkg::FULL_COVER - alpha;

   always_comb begin
      a_sum_r_in = 16'(colour[7:0]) * 16'(alpha) + 16'(pix_r) * 16'(inv_alpha);
      a_sum_g_in = 16'(colour[15:8]) * 16'(alpha) + 16'(pix_g) * 16'(inv_alpha);
      a_sum_b_in = 16'(colour[23:16]) * 16'(alpha) + 16'(pix_b) * 16'(inv_alpha);
   end

   assign q_r   = div255(a_sum_r_ff);
   assign q_g   = div255(a_sum_g_ff);
   assign q_b   = div255(a_sum_b_ff);
   assign solid = {colour[7:3], colour[15:10], colour[23:19]};

   always_comb begin
      wr_in.valid = a_valid_ff;
      wr_in.addr  = a_addr_ff;
      // full coverage ignores the old pixel entirely
      if (alpha == csb_pkg::FULL_COVER) begin
         wr_in.data = solid;
      end else begin
         wr_in.data = {q_r[7:3], q_g[7:2], q_b[7:3]};
      end
   end

   always_ff @(posedge clock) begin
      a_addr_ff  <= in_addr;
      a_sum_r_ff <= a_sum_r_in;
      a_sum_g_ff <= a_sum_g_in;
      a_sum_b_ff <= a_sum_b_in;
      wr_ff.addr <= wr_in.addr;
      wr_ff.data <= wr_in.data;
      if (reset) begin
         a_valid_ff  <= 1'b0;
         wr_ff.valid <= 1'b0;
      end else begin
         a_valid_ff  <= in_valid;
         wr_ff.valid <= wr_in.valid;
      end
   end

   assign wr_out = wr_ff;
   assign busy   = a_valid_ff | wr_ff.valid;

endmodule

>>> src/coverage_span_blend_rgb565_core.sv
// coverage span blender top level: control sequencer, frame store, result register
// depends on csb_pkg and csb_blend
//
// sequence: each item moves through setup, a run step for each of the n columns left after
//   clipping (none for rows outside the area, at most one for pixel ops), a drain that
//   waits for the last read and write-back, and finish, which registers the result
// throughput: one item at a time; the input opens again as the result is registered; the
//   frame store moves one pixel per cycle, read at the front and written back by the blend
//   pipeline behind the read register
// reset: synchronous, clears the sequencer, result valid and pipeline valids, and sets the
//   configuration registers to their defaults; the frame store itself is not cleared
module coverage_span_blend_rgb565_core (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [11:0] req_row_y,
   input  logic [10:0]        req_span_x,
   input  logic [10:0]        req_span_length,
   input  logic [7:0]         req_coverage,
   input  logic [15:0]        req_pixel_value,
   input  logic               req_row_end,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_read_pixel,
   output logic [10:0]        rsp_pixels_written,
   output logic               rsp_row_end_echo,
   // configuration writes
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // configuration
   logic [23:0] fill_colour_ff;
   logic [8:0]  active_width_ff;
   logic [7:0]  active_height_ff;
   logic [8:0]  row_stride_ff;

   // sequencer and latched item
   state_type          state_ff, state_in;
   logic [1:0]         op_ff;
   logic signed [11:0] row_y_ff;
   logic [10:0]        span_x_ff;
   logic [10:0]        span_len_ff;
   logic [7:0]         coverage_ff;
   logic [15:0]        pixel_value_ff;
   logic               row_end_ff;

   logic [csb_pkg::BASE_W-1:0] base_ff;
   logic [8:0]                 end_ff, end_in;
   logic [10:0]                cur_x_ff;
   logic [10:0]                count_ff;
   logic [15:0]                rd_result_ff;

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_read_pixel_ff;
   logic [10:0] rsp_written_ff;
   logic        rsp_row_end_ff;

   // frame store
   logic [15:0]                mem [csb_pkg::STORE_SIZE];
   logic [15:0]                mem_q_ff;
   logic                       s1_blend_ff, s1_read_ff;
   logic [csb_pkg::ADDR_W-1:0] s1_addr_ff;

   logic                       req_xfer;
   logic                       row_ok;
   logic [11:0]                span_end;
   logic                       pix_go;
   logic [csb_pkg::SUM_W-1:0]  addr_sum;
   logic                       in_store;
   logic                       pix_hit;
   logic [csb_pkg::ADDR_W-1:0] pix_addr;
   logic                       rd_en, direct_we;
   logic                       rsp_free;
   csb_pkg::blend_wr_type      blend_wr;
   logic                       blend_busy;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // row must be non-negative and below the active height
   assign row_ok = ~row_y_ff[11] && (row_y_ff[10:8] == 3'd0)
                   && (row_y_ff[7:0] < active_height_ff);

   // clipped end column; pixel ops behave as a one-column span
   always_comb begin
      if (op_ff == csb_pkg::OP_BLEND) begin
         span_end = {1'b0, span_x_ff} + {1'b0, span_len_ff};
      end else begin
         span_end = {1'b0, span_x_ff} + 12'd1;
      end
      if (!row_ok || !(op_ff == csb_pkg::OP_BLEND || op_ff == csb_pkg::OP_WRITE
                       || op_ff == csb_pkg::OP_READ)) begin
         end_in = 9'd0;
      end else if (span_end > {3'd0, active_width_ff}) begin
         end_in = active_width_ff;
      end else begin
         end_in = span_end[8:0];
      end
   end

   // per-column address and store bound check
   assign pix_go   = (state_ff == ST_RUN) && (cur_x_ff < {2'd0, end_ff});
   assign addr_sum = csb_pkg::SUM_W'(base_ff) + csb_pkg::SUM_W'(cur_x_ff);
   assign in_store = addr_sum < csb_pkg::SUM_W'(csb_pkg::STORE_SIZE);
   assign pix_hit  = pix_go & in_store;
   assign pix_addr = addr_sum[csb_pkg::ADDR_W-1:0];

   assign rd_en     = pix_hit && (op_ff == csb_pkg::OP_BLEND || op_ff == csb_pkg::OP_READ);
   assign direct_we = pix_hit && (op_ff == csb_pkg::OP_WRITE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_RUN;
         ST_RUN:    if (!pix_go) state_in = ST_DRAIN;
         // wait until the last write-back has landed
         ST_DRAIN:  if (!s1_blend_ff && !s1_read_ff && !blend_busy) state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff          <= req_operation;
         row_y_ff       <= req_row_y;
         span_x_ff      <= req_span_x;
         span_len_ff    <= req_span_length;
         coverage_ff    <= req_coverage;
         pixel_value_ff <= req_pixel_value;
         row_end_ff     <= req_row_end;
      end
      if (state_ff == ST_SETUP) begin
         base_ff      <= csb_pkg::BASE_W'(row_y_ff[7:0]) * csb_pkg::BASE_W'(row_stride_ff);
         end_ff       <= end_in;
         cur_x_ff     <= span_x_ff;
         count_ff     <= 11'd0;
         rd_result_ff <= 16'd0;
      end else begin
         if (pix_go) cur_x_ff <= cur_x_ff + 11'd1;
         if (pix_hit && op_ff != csb_pkg::OP_READ) count_ff <= count_ff + 11'd1;
         if (s1_read_ff) rd_result_ff <= mem_q_ff;
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_read_pixel_ff <= rd_result_ff;
         rsp_written_ff    <= count_ff;
         rsp_row_end_ff    <= row_end_ff;
      end
      s1_addr_ff <= pix_addr;

      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         s1_blend_ff      <= 1'b0;
         s1_read_ff       <= 1'b0;
         fill_colour_ff   <= 24'd0;
         active_width_ff  <= 9'd320;
         active_height_ff <= 8'd240;
         row_stride_ff    <= 9'd320;
      end else begin
         state_ff    <= state_in;
         s1_blend_ff <= rd_en && (op_ff == csb_pkg::OP_BLEND);
         s1_read_ff  <= rd_en && (op_ff == csb_pkg::OP_READ);
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               csb_pkg::CSR_FILL_COLOUR:   fill_colour_ff   <= csr_wdata;
               csb_pkg::CSR_ACTIVE_WIDTH:  active_width_ff  <= csr_wdata[8:0];
               csb_pkg::CSR_ACTIVE_HEIGHT: active_height_ff <= csr_wdata[7:0];
               csb_pkg::CSR_ROW_STRIDE:    row_stride_ff    <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
   end

   // frame store: one read and one write port, registered read data.
   // columns of a span have rising addresses, so the write-back that trails the reads
   // never hits an entry that is still to be read; items do not overlap
   always_ff @(posedge clock) begin
      if (rd_en) mem_q_ff <= mem[pix_addr];
      if (blend_wr.valid) begin
         mem[blend_wr.addr] <= blend_wr.data;
      end else if (direct_we) begin
         mem[pix_addr] <= pixel_value_ff;
      end
   end

   csb_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_blend_ff),
      .in_addr  (s1_addr_ff),
      .in_pixel (mem_q_ff),
      .colour   (fill_colour_ff),
      .alpha    (coverage_ff),
      .wr_out   (blend_wr),
      .busy     (blend_busy)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_pixel     = rsp_read_pixel_ff;
   assign rsp_pixels_written = rsp_written_ff;
   assign rsp_row_end_echo   = rsp_row_end_ff;

endmodule

>>> src/csb_checker.sv
// port-level checks for the coverage span blender, bound to the top level
// depends on coverage_span_blend_rgb565_core
module csb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [15:0]        rsp_read_pixel,
   input logic [10:0]        rsp_pixels_written,
   input logic               rsp_row_end_echo
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_pixel)
         && $stable(rsp_pixels_written) && $stable(rsp_row_end_echo))
      else $error("stalled result changed");

   // one item in flight: the input closes right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // a read never writes, a write never reads back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixels_written != 11'd0 |-> rsp_read_pixel == 16'd0)
      else $error("result both read and wrote");

   // count bounded by the widest active area
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixels_written <= 11'd511)
      else $error("pixel count beyond clip limit");

   // no result right out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind coverage_span_blend_rgb565_core csb_checker u_csb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_read_pixel     (rsp_read_pixel),
   .rsp_pixels_written (rsp_pixels_written),
   .rsp_row_end_echo   (rsp_row_end_echo)
);

>>> sim/testbench.sv
// self-checking testbench for coverage_span_blend_rgb565_core: a directed table, then random
// phases under several register settings and idle patterns, checked against an in-bench model
// depends on csb_pkg and the core with its blend pipeline
module testbench;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 5;
   // longest legal quiet stretch is a hold-off plus one clipped 511 pixel span
   localparam int STUCK_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 400;
   localparam int NUM_PHASES   = 9;
   // code 2'd3 has no name in the package; the block answers it with zeros
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         op;
      logic signed [11:0] row;
      logic [10:0]        col;
      logic [10:0]        len;
      logic [7:0]         cov;
      logic [15:0]        pix;
      logic               last;
   } span_req_type;

   typedef struct {
      logic [15:0] pixel;
      logic [10:0] count;
      logic        echo;
   } span_rsp_type;

   typedef struct {
      span_req_type req;
      bit           fixed;
      span_rsp_type rsp;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_operation;
   logic signed [11:0] req_row_y;
   logic [10:0]        req_span_x;
   logic [10:0]        req_span_length;
   logic [7:0]         req_coverage;
   logic [15:0]        req_pixel_value;
   logic               req_row_end;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [15:0]        rsp_read_pixel;
   logic [10:0]        rsp_pixels_written;
   logic               rsp_row_end_echo;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [23:0]        csr_wdata;

   coverage_span_blend_rgb565_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_row_y          (req_row_y),
      .req_span_x         (req_span_x),
      .req_span_length    (req_span_length),
      .req_coverage       (req_coverage),
      .req_pixel_value    (req_pixel_value),
      .req_row_end        (req_row_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_pixel     (rsp_read_pixel),
      .rsp_pixels_written (rsp_pixels_written),
      .rsp_row_end_echo   (rsp_row_end_echo),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // shadow of the frame store and of the registers, plus a written flag per entry
   logic [15:0] frame_mem [csb_pkg::STORE_SIZE];
   bit          frame_set [csb_pkg::STORE_SIZE];
   logic [23:0] fill_q;
   int          width_q;
   int          height_q;
   int          stride_q;

   span_rsp_type expected_q [$];
   int           fail_count;
   int           result_no;
   int           stuck_cycles;

   // expectation typed into the directed table for the item now on the input
   bit           fixed_next;
   span_rsp_type fixed_rsp_next;

   // idle controls; the hold-off counter lives in the receiver process
   int          send_idle_pct;
   int          rcv_stall_pct;
   bit          hold_request;
   int          hold_left;

   // whether (y, x) lies in the active area and the store; addr gets its store address
   function automatic bit pixel_addr(input int y, input int x, output int addr);
      addr = 0;
      if (y < 0 || y >= height_q || x >= width_q)
         return 1'b0;
      addr = y * stride_q + x;
      return addr < csb_pkg::STORE_SIZE;
   endfunction

   function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] p,
                                              input logic [7:0] a);
      int sum;
      sum = (int'(c) * int'(a) + int'(p) * (int'(csb_pkg::FULL_COVER) - int'(a)))
            / int'(csb_pkg::FULL_COVER);
      return sum[7:0];
   endfunction

   // expected result of one span op, applied to the shadow store
   task automatic blend_predict(input span_req_type it, output span_rsp_type r);
      int          y;
      int          x;
      int          stop;
      int          addr;
      logic [7:0]  cr;
      logic [7:0]  cg;
      logic [7:0]  cb;
      logic [7:0]  nr;
      logic [7:0]  ng;
      logic [7:0]  nb;
      logic [15:0] px;
      logic [15:0] solid;
      y       = it.row;
      r.pixel = '0;
      r.count = '0;
      r.echo  = it.last;
      cr      = fill_q[7:0];
      cg      = fill_q[15:8];
      cb      = fill_q[23:16];
      solid   = {cr[7:3], cg[7:2], cb[7:3]};
      case (it.op)
         csb_pkg::OP_BLEND: begin
            stop = int'(it.col) + int'(it.len);
            if (stop > width_q)
               stop = width_q;
            if (y >= 0 && y < height_q) begin
               for (x = int'(it.col); x < stop; x++) begin
                  if (pixel_addr(y, x, addr)) begin
                     if (it.cov == csb_pkg::FULL_COVER) begin
                        frame_mem[addr] = solid;
                     end else begin
                        // unpack without bit replication, blend, repack by truncation
                        px = frame_mem[addr];
                        nr = mix_channel(cr, {px[15:11], 3'b000}, it.cov);
                        ng = mix_channel(cg, {px[10:5], 2'b00}, it.cov);
                        nb = mix_channel(cb, {px[4:0], 3'b000}, it.cov);
                        frame_mem[addr] = {nr[7:3], ng[7:2], nb[7:3]};
                     end
                     frame_set[addr] = 1'b1;
                     r.count++;
                  end
               end
            end
         end
         csb_pkg::OP_WRITE: begin
            if (pixel_addr(y, int'(it.col), addr)) begin
               frame_mem[addr] = it.pix;
               frame_set[addr] = 1'b1;
               r.count = 11'd1;
            end
         end
         csb_pkg::OP_READ: begin
            if (pixel_addr(y, int'(it.col), addr))
               r.pixel = frame_mem[addr];
         end
         default: ;
      endcase
   endtask

   // never read an entry that has not been written: partial blends over fresh
   // entries become solid fills, reads of fresh entries become writes
   function automatic span_req_type make_legal(input span_req_type it);
      int y;
      int x;
      int stop;
      int addr;
      y = it.row;
      if (it.op == csb_pkg::OP_BLEND && it.cov != csb_pkg::FULL_COVER
          && y >= 0 && y < height_q) begin
         stop = int'(it.col) + int'(it.len);
         if (stop > width_q)
            stop = width_q;
         for (x = int'(it.col); x < stop; x++)
            if (pixel_addr(y, x, addr) && !frame_set[addr])
               it.cov = csb_pkg::FULL_COVER;
      end
      if (it.op == csb_pkg::OP_READ && pixel_addr(y, int'(it.col), addr) && !frame_set[addr])
         it.op = csb_pkg::OP_WRITE;
      return it;
   endfunction

   // mostly in-area spans and pixels, with a share of rows and columns out of range
   function automatic span_req_type random_span();
      span_req_type it;
      int           k;
      k = $urandom_range(99);
      if (k < 45)
         it.op = csb_pkg::OP_BLEND;
      else if (k < 70)
         it.op = csb_pkg::OP_WRITE;
      else if (k < 97)
         it.op = csb_pkg::OP_READ;
      else
         it.op = OP_UNUSED;
      k = $urandom_range(99);
      if (k < 80 && height_q > 0)
         it.row = 12'($urandom_range(height_q - 1));
      else if (k < 90)
         it.row = 12'($urandom_range(4095, 2048));
      else
         it.row = 12'($urandom_range(4095));
      k = $urandom_range(99);
      if (k < 80 && width_q > 0)
         it.col = 11'($urandom_range(width_q - 1));
      else
         it.col = 11'($urandom_range(2047));
      k = $urandom_range(99);
      if (k < 70)
         it.len = 11'($urandom_range(32));
      else if (k < 90)
         it.len = 11'($urandom_range(320));
      else
         it.len = 11'($urandom_range(1024));
      k = $urandom_range(99);
      if (k < 30)
         it.cov = csb_pkg::FULL_COVER;
      else if (k < 40)
         it.cov = 8'd0;
      else
         it.cov = 8'($urandom_range(255));
      it.pix  = 16'($urandom_range(65535));
      it.last = ($urandom_range(99) < 30);
      return it;
   endfunction

   function automatic dir_row_type dir_entry(input logic [1:0] op, input int row,
                                             input int col, input int len, input int cov,
                                             input int pix, input bit last, input bit fixed,
                                             input int want_pixel, input int want_count);
      dir_row_type d;
      d.req.op    = op;
      d.req.row   = row[11:0];
      d.req.col   = col[10:0];
      d.req.len   = len[10:0];
      d.req.cov   = cov[7:0];
      d.req.pix   = pix[15:0];
      d.req.last  = last;
      d.fixed     = fixed;
      d.rsp.pixel = want_pixel[15:0];
      d.rsp.count = want_count[10:0];
      d.rsp.echo  = last;
      return d;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on result %0d: %s is %0h, expected %0h", result_no, what, got, want);
      fail_count++;
   endtask

   // register write, only called while the block is idle; the shadow follows at once
   task automatic write_csr(input logic [1:0] idx, input logic [23:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         csb_pkg::CSR_FILL_COLOUR:   fill_q   = value;
         csb_pkg::CSR_ACTIVE_WIDTH:  width_q  = int'(value[8:0]);
         csb_pkg::CSR_ACTIVE_HEIGHT: height_q = int'(value[7:0]);
         csb_pkg::CSR_ROW_STRIDE:    stride_q = int'(value[8:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // offer one item from a falling edge, with random idle cycles ahead of it,
   // and return at the falling edge after its transfer
   task automatic send_span(input span_req_type it, input bit fixed, input span_rsp_type want);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      fixed_next      = fixed;
      fixed_rsp_next  = want;
      req_operation   <= it.op;
      req_row_y       <= it.row;
      req_span_x      <= it.col;
      req_span_length <= it.len;
      req_coverage    <= it.cov;
      req_pixel_value <= it.pix;
      req_row_end     <= it.last;
      req_valid       <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // stop offering until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   // receiver: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rcv_stall_pct > 0 && $urandom_range(99) < rcv_stall_pct);
      end
   end

   // monitor: check each result transfer, predict each request transfer,
   // and count cycles in which neither channel moves
   always @(posedge clock) begin
      span_req_type it;
      span_rsp_type got;
      span_rsp_type want;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            result_no++;
            if (expected_q.size() == 0) begin
               report_mismatch("result with none expected, pixels_written",
                               rsp_pixels_written, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_read_pixel !== want.pixel)
                  report_mismatch("read_pixel", rsp_read_pixel, want.pixel);
               if (rsp_pixels_written !== want.count)
                  report_mismatch("pixels_written", rsp_pixels_written, want.count);
               if (rsp_row_end_echo !== want.echo)
                  report_mismatch("row_end_echo", rsp_row_end_echo, want.echo);
            end
         end
         if (req_valid && !req_stall) begin
            moved   = 1'b1;
            it.op   = req_operation;
            it.row  = req_row_y;
            it.col  = req_span_x;
            it.len  = req_span_length;
            it.cov  = req_coverage;
            it.pix  = req_pixel_value;
            it.last = req_row_end;
            // the shadow store is updated either way; typed rows override the result
            blend_predict(it, got);
            if (fixed_next)
               expected_q.push_back(fixed_rsp_next);
            else
               expected_q.push_back(got);
         end
         stuck_cycles = moved ? 0 : stuck_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      dir_row_type  dir_tab [$];
      span_rsp_type none;
      span_req_type it;
      logic [23:0]  fill;
      int           w;
      int           h;
      int           s;
      int           count;
      bit           pause;
      bit           hold;
      int           phase;
      int           n;

      // every input known from time zero
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = csb_pkg::OP_BLEND;
      req_row_y       = '0;
      req_span_x      = '0;
      req_span_length = '0;
      req_coverage    = '0;
      req_pixel_value = '0;
      req_row_end     = 1'b0;
      rsp_stall       = 1'b0;
      csr_we          = 1'b0;
      csr_index       = csb_pkg::CSR_FILL_COLOUR;
      csr_wdata       = '0;
      fail_count      = 0;
      result_no       = 0;
      stuck_cycles    = 0;
      fixed_next      = 1'b0;
      send_idle_pct   = 0;
      rcv_stall_pct   = 0;
      hold_request    = 1'b0;
      hold_left       = 0;
      none            = '{pixel: '0, count: '0, echo: 1'b0};
      fill_q          = '0;
      width_q         = csb_pkg::FB_WIDTH;
      height_q        = csb_pkg::FB_HEIGHT;
      stride_q        = csb_pkg::FB_WIDTH;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(csb_pkg::CSR_FILL_COLOUR, 24'hFF8040);
      write_csr(csb_pkg::CSR_ACTIVE_WIDTH, 24'(csb_pkg::FB_WIDTH));
      write_csr(csb_pkg::CSR_ACTIVE_HEIGHT, 24'(csb_pkg::FB_HEIGHT));
      write_csr(csb_pkg::CSR_ROW_STRIDE, 24'(csb_pkg::FB_WIDTH));

      // directed table: op, row, col, len, cov, pixel, row_end, typed, read_pixel, written
      // solid rows first so every later partial blend and read lands on written entries
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 0, 0, 320, 255, 16'h0000, 0, 1, 0, 320));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 1, 0, 1024, 255, 16'hFFFF, 1, 1, 0, 320));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 2, 100, 0, 255, 0, 0, 1, 0, 0));
      // rows outside the active height
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, -1, 0, 10, 255, 0, 0, 1, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, -2048, 5, 5, 0, 0, 0, 1, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 240, 0, 5, 128, 0, 0, 1, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 2047, 0, 5, 255, 0, 1, 1, 0, 0));
      // span ends clipped at the active width
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 2, 319, 5, 255, 0, 0, 1, 0, 1));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 2, 320, 5, 255, 0, 0, 1, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 2, 2047, 1024, 255, 0, 1, 1, 0, 0));
      // pixel write and read back, including the far corner
      dir_tab.push_back(dir_entry(csb_pkg::OP_WRITE, 0, 3, 0, 0, 16'hFFFF, 0, 1, 0, 1));
      dir_tab.push_back(dir_entry(csb_pkg::OP_READ, 0, 3, 0, 0, 0, 0, 1, 16'hFFFF, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_WRITE, 0, 4, 0, 0, 16'h0000, 0, 1, 0, 1));
      dir_tab.push_back(dir_entry(csb_pkg::OP_WRITE, 239, 319, 0, 0, 16'hA5A5, 0, 1, 0, 1));
      dir_tab.push_back(dir_entry(csb_pkg::OP_READ, 239, 319, 0, 0, 0, 1, 1, 16'hA5A5, 0));
      // partial coverage over known pixels
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 0, 3, 2, 0, 0, 0, 0, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 0, 3, 2, 128, 0, 0, 0, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 0, 3, 2, 254, 0, 0, 0, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_READ, 0, 3, 0, 0, 0, 0, 0, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_READ, 0, 4, 0, 0, 0, 1, 0, 0, 0));
      // pixel ops outside the area
      dir_tab.push_back(dir_entry(csb_pkg::OP_WRITE, 0, 2047, 0, 0, 16'h1234, 0, 1, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_READ, -1, 0, 0, 0, 0, 0, 1, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_READ, 240, 0, 0, 0, 0, 0, 1, 0, 0));
      // unused code answers zeros with the flag echoed
      dir_tab.push_back(dir_entry(OP_UNUSED, 0, 0, 0, 0, 16'hFFFF, 1, 1, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_BLEND, 1, 10, 20, 1, 0, 1, 0, 0, 0));
      dir_tab.push_back(dir_entry(csb_pkg::OP_READ, 1, 15, 0, 0, 0, 0, 0, 0, 0));

      foreach (dir_tab[i])
         send_span(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].rsp);
      drain_results();

      // random phases, each with its own register setting and idle pattern
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         fill  = 24'($urandom_range(24'hFFFFFF));
         w     = csb_pkg::FB_WIDTH;
         h     = csb_pkg::FB_HEIGHT;
         s     = csb_pkg::FB_WIDTH;
         count = 60;
         pause = 1'b0;
         hold  = 1'b0;
         send_idle_pct = 0;
         rcv_stall_pct = 0;
         case (phase)
            0: count = 90;
            1: begin
               fill          = 24'hFFFFFF;
               send_idle_pct = 67;
               pause         = 1'b1;
               count         = 70;
            end
            2: begin
               // smallest area, single entry
               fill          = 24'h000000;
               w             = 1;
               h             = 1;
               s             = 1;
               rcv_stall_pct = 67;
               count         = 40;
            end
            3: begin
               // widest register values, addresses run past the store
               w             = 511;
               h             = 255;
               s             = 511;
               send_idle_pct = 9;
               rcv_stall_pct = 9;
               hold          = 1'b1;
               count         = 70;
            end
            4: begin
               w     = 0;
               count = 20;
            end
            5: begin
               h             = 0;
               s             = 0;
               send_idle_pct = 9;
               rcv_stall_pct = 9;
               count         = 20;
            end
            6: begin
               // zero stride folds every row onto the first
               s             = 0;
               rcv_stall_pct = 67;
            end
            7: begin
               w             = $urandom_range(511, 1);
               h             = $urandom_range(255, 1);
               s             = $urandom_range(511, 1);
               send_idle_pct = 67;
               rcv_stall_pct = 67;
               count         = 90;
            end
            8: begin
               // unit stride overlaps consecutive rows
               s             = 1;
               send_idle_pct = $urandom_range(67);
               rcv_stall_pct = $urandom_range(67);
               hold          = 1'b1;
            end
            default: ;
         endcase
         write_csr(csb_pkg::CSR_FILL_COLOUR, fill);
         write_csr(csb_pkg::CSR_ACTIVE_WIDTH, 24'(w));
         write_csr(csb_pkg::CSR_ACTIVE_HEIGHT, 24'(h));
         write_csr(csb_pkg::CSR_ROW_STRIDE, 24'(s));
         // receiver holds off while the sender keeps offering, so the input backs up
         if (hold)
            hold_request = 1'b1;
         for (n = 0; n < count; n++) begin
            if (pause && n == count / 2)
               drain_results();
            it = make_legal(random_span());
            send_span(it, 1'b0, none);
         end
         drain_results();
      end

      // let any stray result show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
